[hw/rtl/utf16_to_gb2312_encoder_assert.svh]
// assertion macros for the utf16 to gb2312 encoder checker
// expects a clock clk_i and an active-low reset rst_ni in the using scope
`ifndef UTF16_TO_GB2312_ENCODER_ASSERT_SVH
`define UTF16_TO_GB2312_ENCODER_ASSERT_SVH

// same-cycle implication
`define U2GB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("u2gb checker: same-cycle property failed");

// next-cycle implication
`define U2GB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("u2gb checker: next-cycle property failed");

`endif

[hw/rtl/u2gb_pkg.sv]
// shared types and constants of the utf16 to gb2312 encoder
// no dependencies
`timescale 1ns / 1ps

package u2gb_pkg;

  // mapping table geometry
  localparam int TableEntries = 8192;
  localparam int TblAw        = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int CntW         = $clog2(TableEntries + 1);

  // field widths
  localparam int EntriesW = 14;
  localparam int IndexW   = 13;
  localparam int CodeW    = 16;
  localparam int ByteW    = 8;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 16;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgEntriesInUse = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCapacity     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCountOnly    = 2'd2;

  // command codes
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdText = 1'b1;

  // code points and masks
  localparam logic [CodeW-1:0] NotFoundCode  = 16'hA1F5;
  localparam logic [CodeW-1:0] SurrogateMask = 16'hFC00;
  localparam logic [CodeW-1:0] HighSurrogate = 16'hD800;
  localparam logic [CodeW-1:0] LowSurrogate  = 16'hDC00;
  localparam logic [ByteW-1:0] LeadMin       = 8'h81;
  localparam logic [ByteW-1:0] LeadMax       = 8'hFE;
  localparam logic [CodeW-1:0] LowByteMask   = 16'h00FF;

  // one result word
  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             byte_valid;
    logic             last;
    logic [15:0]      total_bytes;
    logic             truncated;
  } res_t;

  // table write from load words
  typedef struct packed {
    logic             en;
    logic [TblAw-1:0] addr;
    logic [CodeW-1:0] key;
    logic [CodeW-1:0] value;
  } tbl_wr_t;

  // lookup request
  typedef struct packed {
    logic             start;
    logic [CodeW-1:0] unit;
    logic [CntW-1:0]  count;
  } scan_req_t;

  // lookup answer
  typedef struct packed {
    logic             done;
    logic [CodeW-1:0] code;
  } scan_rsp_t;

endpackage

[hw/rtl/u2gb_in_if.sv]
// input channel of the encoder: load items and text units
// uses u2gb_pkg for field widths
`timescale 1ns / 1ps

interface u2gb_in_if
  import u2gb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              command;
  logic [IndexW-1:0] entry_index;
  logic [CodeW-1:0]  entry_key;
  logic [CodeW-1:0]  entry_value;
  logic [CodeW-1:0]  text_unit;

  modport source (
    output valid, command, entry_index, entry_key, entry_value, text_unit,
    input  ready
  );
  modport sink (
    input  valid, command, entry_index, entry_key, entry_value, text_unit,
    output ready
  );
endinterface

[hw/rtl/u2gb_out_if.sv]
// output channel of the encoder: gb2312 bytes and string totals
// uses u2gb_pkg for field widths
`timescale 1ns / 1ps

interface u2gb_out_if
  import u2gb_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             byte_valid;
  logic             last;
  logic [15:0]      total_bytes;
  logic             truncated;

  modport source (
    output valid, out_byte, byte_valid, last, total_bytes, truncated,
    input  ready
  );
  modport sink (
    input  valid, out_byte, byte_valid, last, total_bytes, truncated,
    output ready
  );
endinterface

[hw/rtl/utf16_to_gb2312_encoder.sv]
// top level of the utf16 to gb2312 encoder: config registers, string sequencer, output word
// depends on u2gb_pkg, u2gb_in_if, u2gb_out_if and u2gb_scan
`timescale 1ns / 1ps

// Usage
// in_i takes two kinds of words. A load word (command 0) writes one key/value pair
// into the mapping table and gives no result. A text word (command 1)
// carries one UTF-16 unit; it gives zero, one or two result words on out_o.
// A unit 0 gives the terminator word with last set and the string total.
// Config is written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user writes it only
// while the block is idle, which the block itself does not enforce.
// A text unit that is looked up runs the key scan over min(entries_in_use, table size)
// entries, which reads one table entry a cycle from the single read port of the table
// ram; a hit ends the scan early. Surrogates, terminators and ignored units skip
// the scan.
// in_i.ready is high only while the sequencer is idle; a result word waiting in the
// output register does not hold off the next input word.
// When out_o is stalled the output word holds, and the sequencer waits for it.
// Reset clears the config to its defaults and starts a new string; the table
// contents stay undefined until loaded.
module utf16_to_gb2312_encoder
  import u2gb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  u2gb_in_if.sink             in_i,
  u2gb_out_if.source          out_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StCode = 3'd2;
  localparam logic [2:0] StOut0 = 3'd3;
  localparam logic [2:0] StOut1 = 3'd4;

  logic [2:0]          state_q, state_d;
  logic [EntriesW-1:0] entries_q, entries_d;
  logic [15:0]         cap_q, cap_d;
  logic                cnt_only_q, cnt_only_d;
  logic                skip_q, skip_d;
  logic [15:0]         used_q, used_d;
  logic                stop_q, stop_d;
  logic [CodeW-1:0]    code_q, code_d;
  res_t                res0_q, res0_d, res1_q, res1_d;
  logic                two_q, two_d;
  logic                out_vld_q, out_vld_d;
  res_t                out_q, out_d;

  tbl_wr_t             tbl_wr;
  scan_req_t           scan_req;
  scan_rsp_t           scan_rsp;

  logic                accept;
  logic                out_free;
  logic [CodeW-1:0]    unit;
  logic                is_high, is_low;
  logic                wide;
  logic [16:0]         sum_one, sum_two, sum_sel;
  logic [CntW-1:0]     scan_n;

  u2gb_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (tbl_wr),
    .req_i  (scan_req),
    .rsp_o  (scan_rsp)
  );

  // config register writes
  always_comb begin
    entries_d  = entries_q;
    cap_d      = cap_q;
    cnt_only_d = cnt_only_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgEntriesInUse: entries_d  = cfg_wdata_i[EntriesW-1:0];
        CfgCapacity:     cap_d      = cfg_wdata_i;
        CfgCountOnly:    cnt_only_d = cfg_wdata_i[0];
        default:         ;
      endcase
    end
  end

  // handshake and unit classification
  assign in_i.ready = (state_q == StIdle);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_vld_q || out_o.ready;
  assign unit       = in_i.text_unit;
  assign is_high    = (unit & SurrogateMask) == HighSurrogate;
  assign is_low     = (unit & SurrogateMask) == LowSurrogate;
  assign scan_n     = (32'(entries_q) > TableEntries) ? CntW'(TableEntries)
                                                      : CntW'(entries_q);

  // width of the mapped code and the byte count sums
  assign wide    = (code_q[15:8] >= LeadMin) && (code_q[15:8] <= LeadMax);
  assign sum_one = {1'b0, used_q} + 17'd1;
  assign sum_two = {1'b0, used_q} + 17'd2;
  assign sum_sel = wide ? sum_two : sum_one;

  // table writes from load words
  always_comb begin
    tbl_wr.en    = accept && (in_i.command == CmdLoad) &&
                   (32'(in_i.entry_index) < TableEntries);
    tbl_wr.addr  = TblAw'(in_i.entry_index);
    tbl_wr.key   = in_i.entry_key;
    tbl_wr.value = in_i.entry_value;
  end

  // string sequencer
  always_comb begin
    state_d        = state_q;
    skip_d         = skip_q;
    used_d         = used_q;
    stop_d         = stop_q;
    code_d         = code_q;
    res0_d         = res0_q;
    res1_d         = res1_q;
    two_d          = two_q;
    out_vld_d      = out_vld_q && !out_o.ready;
    out_d          = out_q;
    scan_req.start = 1'b0;
    scan_req.unit  = unit;
    scan_req.count = scan_n;
    unique case (state_q)
      StIdle: begin
        if (accept && (in_i.command == CmdText)) begin
          if (unit == '0) begin
            res0_d.out_byte    = '0;
            res0_d.byte_valid  = !cnt_only_q;
            res0_d.last        = 1'b1;
            res0_d.total_bytes = used_q;
            res0_d.truncated   = !cnt_only_q && stop_q;
            two_d              = 1'b0;
            skip_d             = 1'b0;
            used_d             = 16'd1;
            stop_d             = 1'b0;
            state_d            = StOut0;
          end else if (!cnt_only_q && stop_q) begin
            state_d = StIdle;
          end else if (!cnt_only_q && (used_q >= cap_q)) begin
            stop_d = 1'b1;
          end else if (skip_q && is_low) begin
            skip_d = 1'b0;
          end else if (is_high) begin
            skip_d  = 1'b1;
            code_d  = NotFoundCode;
            state_d = StCode;
          end else begin
            skip_d         = 1'b0;
            scan_req.start = 1'b1;
            state_d        = StScan;
          end
        end
      end
      StScan: begin
        if (scan_rsp.done) begin
          code_d  = scan_rsp.code;
          state_d = StCode;
        end
      end
      StCode: begin
        res0_d.byte_valid  = 1'b1;
        res0_d.last        = 1'b0;
        res0_d.total_bytes = '0;
        res0_d.truncated   = 1'b0;
        res1_d             = res0_d;
        res0_d.out_byte    = wide ? code_q[15:8] : code_q[ByteW-1:0];
        res1_d.out_byte    = 8'(code_q & LowByteMask);
        two_d              = wide;
        state_d            = StIdle;
        if (cnt_only_q) begin
          // count only: saturating total, no bytes
          used_d = sum_sel[16] ? 16'hFFFF : sum_sel[15:0];
        end else if (wide && (sum_two > {1'b0, cap_q})) begin
          stop_d = 1'b1;
        end else begin
          used_d  = sum_sel[15:0];
          state_d = StOut0;
        end
      end
      StOut0: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = res0_q;
          state_d   = two_q ? StOut1 : StIdle;
        end
      end
      StOut1: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          out_d     = res1_q;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      entries_q  <= '0;
      cap_q      <= 16'hFFFF;
      cnt_only_q <= 1'b0;
      skip_q     <= 1'b0;
      used_q     <= 16'd1;
      stop_q     <= 1'b0;
      two_q      <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      entries_q  <= entries_d;
      cap_q      <= cap_d;
      cnt_only_q <= cnt_only_d;
      skip_q     <= skip_d;
      used_q     <= used_d;
      stop_q     <= stop_d;
      two_q      <= two_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    res0_q <= res0_d;
    res1_q <= res1_d;
    out_q  <= out_d;
  end

  // output word
  assign out_o.valid       = out_vld_q;
  assign out_o.out_byte    = out_q.out_byte;
  assign out_o.byte_valid  = out_q.byte_valid;
  assign out_o.last        = out_q.last;
  assign out_o.total_bytes = out_q.total_bytes;
  assign out_o.truncated   = out_q.truncated;

endmodule

[hw/rtl/u2gb_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module u2gb_ram #(
  parameter int Width = 32,
  parameter int Depth = 8192,
  parameter int Aw    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

[hw/rtl/u2gb_scan.sv]
// table store and lookup unit: one key compare per cycle over the entries in use
// depends on u2gb_pkg and u2gb_ram
`timescale 1ns / 1ps

module u2gb_scan
  import u2gb_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tbl_wr_t   wr_i,
  input  scan_req_t req_i,
  output scan_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 dv_q, dv_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW-1:0]      n_q, n_d;
  logic [CodeW-1:0]     unit_q, unit_d;
  logic                 issue;
  logic                 hit;
  logic [2*CodeW-1:0]   rdata;

  // key in the upper half, value in the lower half
  u2gb_ram #(
    .Width (2 * CodeW),
    .Depth (TableEntries)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_i.en),
    .waddr_i (wr_i.addr),
    .wdata_i ({wr_i.key, wr_i.value}),
    .re_i    (issue),
    .raddr_i (cnt_q[TblAw-1:0]),
    .rdata_o (rdata)
  );

  // read issue and compare of the word read the cycle before
  always_comb begin
    issue = busy_q && (cnt_q < n_q);
    hit   = dv_q && (rdata[2*CodeW-1:CodeW] == unit_q);
    rsp_o.done = busy_q && (hit || (cnt_q == n_q));
    rsp_o.code = hit ? rdata[CodeW-1:0] : NotFoundCode;
  end

  // sequencer
  always_comb begin
    busy_d = busy_q;
    dv_d   = issue;
    cnt_d  = cnt_q;
    n_d    = n_q;
    unit_d = unit_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      dv_d   = 1'b0;
      cnt_d  = '0;
      n_d    = req_i.count;
      unit_d = req_i.unit;
    end else if (rsp_o.done) begin
      busy_d = 1'b0;
    end else if (issue) begin
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      dv_q   <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      dv_q   <= dv_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    unit_q <= unit_d;
  end

endmodule

[hw/rtl/u2gb_checker.sv]
// port-level checker of the encoder output channel, bound to the top level
// depends on utf16_to_gb2312_encoder_assert.svh and u2gb_pkg
`timescale 1ns / 1ps
`include "utf16_to_gb2312_encoder_assert.svh"

module u2gb_checker
  import u2gb_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid,
  input logic             out_ready,
  input logic [ByteW-1:0] out_byte,
  input logic             byte_valid,
  input logic             last,
  input logic [15:0]      total_bytes,
  input logic             truncated
);

  // a stalled word holds
  `U2GB_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(last) && $stable(total_bytes))

  // terminator word carries a zero byte
  `U2GB_ASSERT_NOW(a_term_zero, out_valid && last, out_byte == '0)

  // data words carry a byte and no string summary
  `U2GB_ASSERT_NOW(a_data_word, out_valid && !last, byte_valid && (total_bytes == '0) && !truncated)

  // count-only terminator never reports truncation
  `U2GB_ASSERT_NOW(a_count_trunc, out_valid && !byte_valid, !truncated)

endmodule

bind utf16_to_gb2312_encoder u2gb_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid   (out_o.valid),
  .out_ready   (out_o.ready),
  .out_byte    (out_o.out_byte),
  .byte_valid  (out_o.byte_valid),
  .last        (out_o.last),
  .total_bytes (out_o.total_bytes),
  .truncated   (out_o.truncated)
);
